[hw/rtl/rect_border_hit_test_macros.svh]
// Assertion macros used by the rect_border_hit_test top level.
`ifndef RECT_BORDER_HIT_TEST_MACROS_SVH
`define RECT_BORDER_HIT_TEST_MACROS_SVH
`ifndef ASSERT_OFF
`define RBHT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rbht assertion failed");
`define RBHT_ASSERT_RST(name, clk, prop) \
   name: assert property (@(posedge clk) prop) else $error("rbht reset assertion failed");
`else
`define RBHT_ASSERT(name, clk, rst, prop)
`define RBHT_ASSERT_RST(name, clk, prop)
`endif
`endif

[hw/rtl/rbht_pkg.sv]
// Types, constants and register codes of the rectangle border hit test.
package rbht_pkg;
   localparam int CoordWidth = 24;
   localparam int DistWidth  = 16;
   localparam int CsrIdxWidth = 3;
   localparam int MaskWidth  = 4;
   localparam int Latency    = 8;

   localparam logic [CsrIdxWidth-1:0] CSR_M_XX    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_M_YX    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_M_XY    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_M_YY    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_SHIFT_X = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_SHIFT_Y = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_SEL_DIST = 3'd6;

   localparam logic signed [CoordWidth-1:0] M_ONE = 24'sd65536;
   localparam logic [DistWidth-1:0] SEL_DIST_RESET = 16'd1792;
   localparam logic signed [CoordWidth-1:0] Q16_MAX = 24'sh7FFFFF;
   localparam logic signed [CoordWidth-1:0] Q16_MIN = 24'sh800000;

   typedef logic signed [CoordWidth-1:0] q16_type;

   typedef struct packed {
      q16_type x;
      q16_type y;
   } point_type;

   typedef struct packed {
      q16_type m_xx;
      q16_type m_yx;
      q16_type m_xy;
      q16_type m_yy;
      q16_type shift_x;
      q16_type shift_y;
      logic [DistWidth-1:0] select_distance;
   } cfg_type;
endpackage

[hw/rtl/rbht_if.sv]
// Channel interfaces: query request, mask response and register writes.
interface rbht_req_if;
   logic valid;
   logic ready;
   logic signed [23:0] rect_left;
   logic signed [23:0] rect_top;
   logic signed [23:0] rect_right;
   logic signed [23:0] rect_bottom;
   logic signed [23:0] point_x;
   logic signed [23:0] point_y;
   modport source (output valid, rect_left, rect_top, rect_right, rect_bottom,
                   point_x, point_y, input ready);
   modport sink   (input valid, rect_left, rect_top, rect_right, rect_bottom,
                   point_x, point_y, output ready);
endinterface

interface rbht_rsp_if;
   logic valid;
   logic ready;
   logic [3:0] border_mask;
   modport source (output valid, border_mask, input ready);
   modport sink   (input valid, border_mask, output ready);
endinterface

interface rbht_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/rect_border_hit_test.sv]
// Top level of the rectangle border hit test.
//  channel  dir  content
//  req_bus  in   rect_left/top/right/bottom, point_x/y (Q8.16)
//  rsp_bus  out  border_mask (top, bottom, left, right)
//  csr_bus  in   index, data register write
// One transaction per cycle while the response is not stalled; each result comes
// out of the 8-stage pipeline (transform 2, edge test 6).
// A stalled response freezes the whole pipeline; nothing is dropped.
// Synchronous reset clears valid bits and loads register defaults; no clearing pass.
`include "rect_border_hit_test_macros.svh"
module rect_border_hit_test (
   input  logic clock,
   input  logic reset,
   rbht_req_if.sink   req_bus,
   rbht_rsp_if.source rsp_bus,
   rbht_csr_if.sink   csr_bus
);
   import rbht_pkg::*;

   cfg_type cfg;
   logic en;
   logic [Latency-1:0] vld_ff, vld_in;
   point_type pt_in, pt_x;
   point_type corner [4];
   logic [MaskWidth-1:0] hit;

   rbht_csr u_csr (.clock(clock), .reset(reset), .csr_bus(csr_bus), .cfg(cfg));

   assign en = !vld_ff[Latency-1] || rsp_bus.ready;
   assign req_bus.ready = en;
   assign vld_in = en ? {vld_ff[Latency-2:0], req_bus.valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign pt_in.x = req_bus.point_x;
   assign pt_in.y = req_bus.point_y;

   rbht_xform u_xform (
      .clock(clock), .en(en), .cfg(cfg),
      .rect_left(req_bus.rect_left), .rect_top(req_bus.rect_top),
      .rect_right(req_bus.rect_right), .rect_bottom(req_bus.rect_bottom),
      .pt(pt_in), .corner(corner), .pt_out(pt_x)
   );

   rbht_edge u_top (.clock(clock), .en(en), .p1(corner[0]), .p2(corner[1]),
                    .pt(pt_x), .sel_dist(cfg.select_distance), .hit(hit[0]));
   rbht_edge u_bot (.clock(clock), .en(en), .p1(corner[2]), .p2(corner[3]),
                    .pt(pt_x), .sel_dist(cfg.select_distance), .hit(hit[1]));
   rbht_edge u_lft (.clock(clock), .en(en), .p1(corner[0]), .p2(corner[3]),
                    .pt(pt_x), .sel_dist(cfg.select_distance), .hit(hit[2]));
   rbht_edge u_rgt (.clock(clock), .en(en), .p1(corner[1]), .p2(corner[2]),
                    .pt(pt_x), .sel_dist(cfg.select_distance), .hit(hit[3]));

   assign rsp_bus.valid = vld_ff[Latency-1];
   assign rsp_bus.border_mask = hit;

   `RBHT_ASSERT(a_accept_enters, clock, reset, req_bus.valid && req_bus.ready |=> vld_ff[0])
   `RBHT_ASSERT(a_stall_holds, clock, reset, rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(hit))
   `RBHT_ASSERT(a_stall_freeze, clock, reset, !en |=> $stable(vld_ff))
   `RBHT_ASSERT_RST(a_reset_empty, clock, reset |=> vld_ff == '0)
endmodule

[hw/rtl/rbht_csr.sv]
// Configuration register file.
module rbht_csr (
   input  logic clock,
   input  logic reset,
   rbht_csr_if.sink csr_bus,
   output rbht_pkg::cfg_type cfg
);
   import rbht_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_M_XX:     cfg_in.m_xx = csr_bus.data;
            CSR_M_YX:     cfg_in.m_yx = csr_bus.data;
            CSR_M_XY:     cfg_in.m_xy = csr_bus.data;
            CSR_M_YY:     cfg_in.m_yy = csr_bus.data;
            CSR_SHIFT_X:  cfg_in.shift_x = csr_bus.data;
            CSR_SHIFT_Y:  cfg_in.shift_y = csr_bus.data;
            CSR_SEL_DIST: cfg_in.select_distance = csr_bus.data[DistWidth-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.m_xx <= M_ONE;
         cfg_ff.m_yx <= '0;
         cfg_ff.m_xy <= '0;
         cfg_ff.m_yy <= M_ONE;
         cfg_ff.shift_x <= '0;
         cfg_ff.shift_y <= '0;
         cfg_ff.select_distance <= SEL_DIST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

[hw/rtl/rbht_xform.sv]
// Two-stage affine transform of the four rectangle corners.
module rbht_xform (
   input  logic clock,
   input  logic en,
   input  rbht_pkg::cfg_type cfg,
   input  rbht_pkg::q16_type rect_left,
   input  rbht_pkg::q16_type rect_top,
   input  rbht_pkg::q16_type rect_right,
   input  rbht_pkg::q16_type rect_bottom,
   input  rbht_pkg::point_type pt,
   output rbht_pkg::point_type corner [4],
   output rbht_pkg::point_type pt_out
);
   import rbht_pkg::*;

   logic signed [47:0] xl_ff, xr_ff, xt_ff, xb_ff;
   logic signed [47:0] yl_ff, yr_ff, yt_ff, yb_ff;
   point_type pt1_ff, pt2_ff;
   point_type corner_ff [4];
   point_type corner_in [4];

   function automatic q16_type affine(input logic signed [47:0] pa,
                                      input logic signed [47:0] pb,
                                      input q16_type t);
      logic signed [49:0] s;
      logic signed [33:0] fl;
      logic signed [34:0] tot;
      q16_type r;
      s = 50'(pa) + 50'(pb) + 50'sd32768;
      fl = s[49:16];
      tot = 35'(fl) + 35'(t);
      if (tot > 35'(Q16_MAX)) r = Q16_MAX;
      else if (tot < 35'(Q16_MIN)) r = Q16_MIN;
      else r = tot[23:0];
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         xl_ff <= cfg.m_xx * rect_left;
         xr_ff <= cfg.m_xx * rect_right;
         xt_ff <= cfg.m_yx * rect_top;
         xb_ff <= cfg.m_yx * rect_bottom;
         yl_ff <= cfg.m_xy * rect_left;
         yr_ff <= cfg.m_xy * rect_right;
         yt_ff <= cfg.m_yy * rect_top;
         yb_ff <= cfg.m_yy * rect_bottom;
         pt1_ff <= pt;
      end
   end

   always_comb begin
      corner_in[0].x = affine(xl_ff, xt_ff, cfg.shift_x);
      corner_in[0].y = affine(yl_ff, yt_ff, cfg.shift_y);
      corner_in[1].x = affine(xr_ff, xt_ff, cfg.shift_x);
      corner_in[1].y = affine(yr_ff, yt_ff, cfg.shift_y);
      corner_in[2].x = affine(xr_ff, xb_ff, cfg.shift_x);
      corner_in[2].y = affine(yr_ff, yb_ff, cfg.shift_y);
      corner_in[3].x = affine(xl_ff, xb_ff, cfg.shift_x);
      corner_in[3].y = affine(yl_ff, yb_ff, cfg.shift_y);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         corner_ff <= corner_in;
         pt2_ff <= pt1_ff;
      end
   end

   assign corner = corner_ff;
   assign pt_out = pt2_ff;
endmodule

[hw/rtl/rbht_edge.sv]
// Six-stage distance test of the query point against one edge.
module rbht_edge (
   input  logic clock,
   input  logic en,
   input  rbht_pkg::point_type p1,
   input  rbht_pkg::point_type p2,
   input  rbht_pkg::point_type pt,
   input  logic [rbht_pkg::DistWidth-1:0] sel_dist,
   output logic hit
);
   import rbht_pkg::*;

   // stage 3: box test and edge/point vectors
   logic bb_in, bb3_ff, bb4_ff, bb5_ff, bb6_ff, bb7_ff;
   logic dg3_ff, dg4_ff, dg5_ff, dg6_ff, dg7_ff;
   logic signed [24:0] vx_ff, vy_ff, wx_ff, wy_ff;
   logic signed [25:0] xmin, xmax, ymin, ymax, px26, py26, d26;
   // stage 4
   logic signed [49:0] pa_ff, pb_ff, vxx_ff, vyy_ff, wxx_ff, wyy_ff;
   // stage 5
   logic signed [50:0] cr, len_s, dsum_s;
   logic [49:0] mag_in, mag_ff, len_ff, dsum_ff;
   logic [31:0] d2_ff;
   // stage 6
   logic [51:0] ahh_ff;
   logic [49:0] ahl_ff;
   logic [47:0] all_ff;
   logic [57:0] rh_ff;
   logic [55:0] rl_ff;
   logic dh6_ff, dh7_ff;
   // stage 7-8
   logic [99:0] c_ff, r_ff;
   logic hit_ff, hit_in;

   always_comb begin
      px26 = 26'(pt.x);
      py26 = 26'(pt.y);
      d26  = signed'(26'(sel_dist));
      xmin = (p1.x < p2.x) ? 26'(p1.x) : 26'(p2.x);
      xmax = (p1.x < p2.x) ? 26'(p2.x) : 26'(p1.x);
      ymin = (p1.y < p2.y) ? 26'(p1.y) : 26'(p2.y);
      ymax = (p1.y < p2.y) ? 26'(p2.y) : 26'(p1.y);
      bb_in = (px26 >= xmin - d26) && (px26 <= xmax + d26) &&
              (py26 >= ymin - d26) && (py26 <= ymax + d26);
   end

   always_comb begin
      cr = 51'(pa_ff) - 51'(pb_ff);
      mag_in = cr[50] ? 50'(-cr) : cr[49:0];
      len_s = 51'(vxx_ff) + 51'(vyy_ff);
      dsum_s = 51'(wxx_ff) + 51'(wyy_ff);
      hit_in = bb7_ff && (dg7_ff ? dh7_ff : (c_ff <= r_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bb3_ff <= bb_in;
         dg3_ff <= (p1.x == p2.x) && (p1.y == p2.y);
         vx_ff <= 25'(p2.x) - 25'(p1.x);
         vy_ff <= 25'(p2.y) - 25'(p1.y);
         wx_ff <= 25'(pt.x) - 25'(p1.x);
         wy_ff <= 25'(pt.y) - 25'(p1.y);

         pa_ff <= vx_ff * wy_ff;
         pb_ff <= vy_ff * wx_ff;
         vxx_ff <= vx_ff * vx_ff;
         vyy_ff <= vy_ff * vy_ff;
         wxx_ff <= wx_ff * wx_ff;
         wyy_ff <= wy_ff * wy_ff;
         bb4_ff <= bb3_ff;
         dg4_ff <= dg3_ff;

         mag_ff <= mag_in;
         len_ff <= len_s[49:0];
         dsum_ff <= dsum_s[49:0];
         d2_ff <= sel_dist * sel_dist;
         bb5_ff <= bb4_ff;
         dg5_ff <= dg4_ff;

         ahh_ff <= mag_ff[49:24] * mag_ff[49:24];
         ahl_ff <= mag_ff[49:24] * mag_ff[23:0];
         all_ff <= mag_ff[23:0] * mag_ff[23:0];
         rh_ff <= d2_ff * len_ff[49:24];
         rl_ff <= d2_ff * len_ff[23:0];
         dh6_ff <= dsum_ff <= 50'(d2_ff);
         bb6_ff <= bb5_ff;
         dg6_ff <= dg5_ff;

         c_ff <= {ahh_ff, 48'd0} + 100'({ahl_ff, 25'd0}) + 100'(all_ff);
         r_ff <= 100'({rh_ff, 24'd0}) + 100'(rl_ff);
         dh7_ff <= dh6_ff;
         bb7_ff <= bb6_ff;
         dg7_ff <= dg6_ff;

         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;
endmodule
